// ----- hdl/dlefr_pkg.sv -----
// ============================================================================
// dlefr_pkg
// Shared types, widths, codes and the check fold for the DLE frame receiver.
// ============================================================================
package dlefr_pkg;

    // Frame store geometry
    localparam int FRAME_DEPTH = 64;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int COUNT_W     = $clog2(FRAME_DEPTH + 1);

    // Field widths
    localparam int BYTE_W       = 8;
    localparam int CHECK_W      = 16;
    localparam int KIND_W       = 3;
    localparam int BYTE_INDEX_W = 6;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int OUT_DATA_W   = 32;

    // Input op codes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // Check mode codes
    localparam logic MODE_SUM = 1'b0;
    localparam logic MODE_CRC = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLY = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DLE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EOF  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_NAK  = 3'd5;

    // Configuration reset values
    localparam logic [CHECK_W-1:0] POLY_RESET = 16'h1021;
    localparam logic [BYTE_W-1:0]  DLE_RESET  = 8'h10;
    localparam logic [BYTE_W-1:0]  EOF_RESET  = 8'h1F;
    localparam logic [BYTE_W-1:0]  ACK_RESET  = 8'h16;
    localparam logic [BYTE_W-1:0]  NAK_RESET  = 8'h19;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_DATA    = 3'd0,
        KIND_ACK     = 3'd1,
        KIND_NAK     = 3'd2,
        KIND_CHK_ERR = 3'd3,
        KIND_TIMEOUT = 3'd4
    } kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;       // take the input request this cycle
        logic replay_read;  // read the frame store at the replay index
        logic replay_load;  // move the read byte into the output register
    } dlefr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;     // output register empty or being drained
        logic replay_start; // accepted byte completes a good data packet
        logic replay_last;  // replay index points at the final stored byte
    } dlefr_status_t;

    // Fold one byte into the running check: additive sum or MSB-first CRC.
    function automatic logic [CHECK_W-1:0] check_fold(
        input logic               mode,
        input logic [CHECK_W-1:0] poly,
        input logic [CHECK_W-1:0] c,
        input logic [BYTE_W-1:0]  b
    );
        logic [CHECK_W-1:0] v;
        if (mode == MODE_SUM)
        begin
            v = c + {8'h00, b};
        end
        else
        begin
            v = c ^ {b, 8'h00};
            for (int i = 0; i < BYTE_W; i++)
            begin
                if (v[CHECK_W-1])
                begin
                    v = {v[CHECK_W-2:0], 1'b0} ^ poly;
                end
                else
                begin
                    v = {v[CHECK_W-2:0], 1'b0};
                end
            end
        end
        return v;
    endfunction

endpackage

// ----- hdl/dle_frame_receiver_checksum.sv -----
// ============================================================================
// dle_frame_receiver_checksum
// DLE-framed packet receiver with additive-sum or CRC-16 check and replay.
// ============================================================================
//
// Channel   Direction  Handshake                   Content
// s_axis    in         s_axis_tvalid/tready        one serial byte or timeout tick
// m_axis    out        m_axis_tvalid/tready        packet results, tlast ends a run
// cfg       in         cfg_valid/cfg_ready         register index and write data
//
// Timing: ack, nak, checksum error and timeout results land in the output
// register at the edge that takes the request. A good data packet replays
// from the frame store byte by byte (registered store read, then output
// load, which waits for a free output register), holding off input until done.
// Reset: rst_n clears frame state and restores register defaults; the frame
// store needs no clearing. Stalls: input waits while the output register is
// full and not being taken, or while a replay is running.
// ============================================================================
module dle_frame_receiver_checksum
    import dlefr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] rx_byte
    input  logic                   s_axis_tuser,   // [0] op
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // [7:0] frame_byte, [13:8] byte_index,
                                                   // [21:14] command_byte, [29:22] error_code
    output logic [KIND_W-1:0]      m_axis_tuser,   // [2:0] kind
    output logic                   m_axis_tlast,   // last
    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    dlefr_cmd_t              cmd;
    dlefr_status_t           status;
    kind_t                   out_kind;
    logic [BYTE_W-1:0]       out_frame_byte;
    logic [BYTE_INDEX_W-1:0] out_byte_index;
    logic [BYTE_W-1:0]       out_command;
    logic [BYTE_W-1:0]       out_error;

    // Register writes must come only while idle; the block does not enforce this and always takes them
    assign cfg_ready = 1'b1;

    // Sequencer: gate input requests and step the replay
    dlefr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Deframing, check, frame store and output register
    dlefr_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_op          (s_axis_tuser),
        .in_byte        (s_axis_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_kind       (out_kind),
        .out_frame_byte (out_frame_byte),
        .out_byte_index (out_byte_index),
        .out_command    (out_command),
        .out_error      (out_error),
        .out_last       (m_axis_tlast)
    );

    // Pack result fields, lowest field first, pad to whole bytes
    assign m_axis_tdata = {2'b00, out_error, out_command, out_byte_index, out_frame_byte};
    assign m_axis_tuser = out_kind;

    // Input is only taken when the output register can absorb a result
    a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
        else $error("input taken while output register blocked");

    // A timeout request always yields a timeout result at the next edge
    a_timeout_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_TIMEOUT))
        |=> (m_axis_tvalid && (m_axis_tuser == KIND_TIMEOUT) && m_axis_tlast))
        else $error("timeout request without timeout result");

    // Results other than data replay are single-result runs with no frame byte
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != KIND_DATA))
        |-> (m_axis_tlast && (m_axis_tdata[7:0] == 8'h00)))
        else $error("non-data result malformed");

    // No new request is taken while a replay run is still unfinished
    a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_DATA) && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input taken during packet replay");

endmodule

// ----- hdl/dlefr_ram.sv -----
// ============================================================================
// dlefr_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module dlefr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/dlefr_ctrl.sv -----
// ============================================================================
// dlefr_ctrl
// Sequencer: accepts requests when idle and steps the data packet replay.
// ============================================================================
module dlefr_ctrl
    import dlefr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  dlefr_status_t status,
    output dlefr_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE) && status.out_free;

    always_comb
    begin
        cmd.accept      = in_ready && in_valid;
        cmd.replay_read = (state_reg == ST_READ);
        cmd.replay_load = (state_reg == ST_SEND) && status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && status.replay_start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (status.out_free)
                begin
                    state_next = status.replay_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/dlefr_dp.sv -----
// ============================================================================
// dlefr_dp
// Datapath: config registers, deframing state, check, frame store, output.
// ============================================================================
module dlefr_dp
    import dlefr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dlefr_cmd_t              cmd,
    output dlefr_status_t           status,
    input  logic                    in_op,
    input  logic [BYTE_W-1:0]       in_byte,
    input  logic                    cfg_valid,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    out_ready,
    output logic                    out_valid,
    output kind_t                   out_kind,
    output logic [BYTE_W-1:0]       out_frame_byte,
    output logic [BYTE_INDEX_W-1:0] out_byte_index,
    output logic [BYTE_W-1:0]       out_command,
    output logic [BYTE_W-1:0]       out_error,
    output logic                    out_last
);

    // Configuration
    logic               mode_reg;
    logic [CHECK_W-1:0] poly_reg;
    logic [BYTE_W-1:0]  dle_reg;
    logic [BYTE_W-1:0]  eof_reg;
    logic [BYTE_W-1:0]  ack_reg;
    logic [BYTE_W-1:0]  nak_reg;

    // Frame state
    logic               in_frame_reg,  in_frame_next;
    logic               escape_reg,    escape_next;
    logic               end_seen_reg,  end_seen_next;
    logic               nak_pend_reg,  nak_pend_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic [1:0]         chk_seen_reg,  chk_seen_next;
    logic [CHECK_W-1:0] check_reg,     check_next;
    logic [BYTE_W-1:0]  command_reg,   command_next;
    logic [BYTE_W-1:0]  last_store_reg;

    // Replay and output
    logic [ADDR_W-1:0]       replay_idx_reg, replay_idx_next;
    logic [COUNT_W-1:0]      replay_cnt_reg;
    logic [BYTE_W-1:0]       replay_cmd_reg;
    logic                    out_valid_reg, out_valid_next;
    kind_t                   out_kind_reg;
    logic [BYTE_W-1:0]       out_fb_reg;
    logic [BYTE_INDEX_W-1:0] out_idx_reg;
    logic [BYTE_W-1:0]       out_cmd_reg;
    logic [BYTE_W-1:0]       out_err_reg;
    logic                    out_last_reg;

    // Step decode
    logic               is_dle;
    logic               is_eof;
    logic               overflow;
    logic               store;
    logic [ADDR_W-1:0]  store_addr;
    logic               complete;
    logic               acked;
    logic               bad;
    logic               stuffed;
    logic [BYTE_W-1:0]  err;
    logic [CHECK_W-1:0] folded;
    logic               single_load;
    kind_t              single_kind;
    logic [BYTE_W-1:0]  single_cmd;
    logic [BYTE_W-1:0]  single_err;
    logic [BYTE_W-1:0]  rd_data;

    assign is_dle   = (in_byte == dle_reg);
    assign is_eof   = (in_byte == eof_reg);
    assign overflow = (count_reg >= COUNT_W'(FRAME_DEPTH));
    assign folded   = check_fold(mode_reg, poly_reg, check_reg, in_byte);

    always_comb
    begin
        in_frame_next = in_frame_reg;
        escape_next   = escape_reg;
        end_seen_next = end_seen_reg;
        nak_pend_next = nak_pend_reg;
        count_next    = count_reg;
        chk_seen_next = chk_seen_reg;
        check_next    = check_reg;
        command_next  = command_reg;
        store         = 1'b0;
        store_addr    = count_reg[ADDR_W-1:0];
        complete      = 1'b0;
        acked         = 1'b0;
        bad           = 1'b0;
        stuffed       = 1'b0;
        err           = '0;
        single_load   = 1'b0;
        single_kind   = KIND_TIMEOUT;
        single_cmd    = command_reg;
        single_err    = '0;

        if (in_op == OP_TIMEOUT)
        begin
            single_load = 1'b1;
        end
        else if (!overflow)
        begin
            if (is_dle && !end_seen_reg)
            begin
                if (!in_frame_reg)
                begin
                    in_frame_next = 1'b1;
                    store_addr    = '0;
                    store         = 1'b1;
                    check_next    = folded;
                    escape_next   = 1'b1;
                end
                else if (escape_reg)
                begin
                    check_next = folded;
                    stuffed    = 1'b1;
                end
                else
                begin
                    escape_next = 1'b1;
                    store       = 1'b1;
                    check_next  = folded;
                end
            end
            else if (is_eof && escape_reg && !end_seen_reg)
            begin
                store         = 1'b1;
                check_next    = folded;
                end_seen_next = 1'b1;
                chk_seen_next = '0;
            end
            else if (end_seen_reg)
            begin
                store         = 1'b1;
                chk_seen_next = chk_seen_reg + 2'd1;
                if (chk_seen_next >= 2'd2)
                begin
                    complete = 1'b1;
                    bad      = ({last_store_reg, in_byte} != check_reg);
                end
            end
            else if (nak_pend_reg)
            begin
                err      = in_byte;
                complete = 1'b1;
                store    = 1'b1;
            end
            else if (in_frame_reg)
            begin
                if (escape_reg && (count_reg == COUNT_W'(1)))
                begin
                    command_next = in_byte;
                    if (in_byte == nak_reg)
                    begin
                        nak_pend_next = 1'b1;
                    end
                    if (in_byte == ack_reg)
                    begin
                        acked    = 1'b1;
                        complete = 1'b1;
                    end
                end
                store      = 1'b1;
                check_next = folded;
            end

            if (!is_dle || stuffed)
            begin
                escape_next = 1'b0;
            end

            if (store)
            begin
                count_next = COUNT_W'(store_addr) + COUNT_W'(1);
            end

            single_cmd = command_next;
            if (complete)
            begin
                if (acked)
                begin
                    single_load = 1'b1;
                    single_kind = KIND_ACK;
                end
                else if (nak_pend_next)
                begin
                    single_load = 1'b1;
                    single_kind = KIND_NAK;
                    single_err  = err;
                end
                else if (bad)
                begin
                    single_load = 1'b1;
                    single_kind = KIND_CHK_ERR;
                end
            end
        end

        // Drop all frame state on timeout, overflow or a finished packet
        if ((in_op == OP_TIMEOUT) || overflow || complete)
        begin
            in_frame_next = 1'b0;
            escape_next   = 1'b0;
            end_seen_next = 1'b0;
            nak_pend_next = 1'b0;
            count_next    = '0;
            chk_seen_next = '0;
            check_next    = '0;
            command_next  = '0;
        end
    end

    assign status.out_free     = !out_valid_reg || out_ready;
    assign status.replay_start = cmd.accept && (in_op == OP_BYTE) && complete && !single_load;
    assign status.replay_last  = ((COUNT_W'(replay_idx_reg) + COUNT_W'(1)) == replay_cnt_reg);

    always_comb
    begin
        replay_idx_next = replay_idx_reg;
        if (status.replay_start)
        begin
            replay_idx_next = '0;
        end
        else if (cmd.replay_load)
        begin
            replay_idx_next = replay_idx_reg + ADDR_W'(1);
        end

        out_valid_next = out_valid_reg;
        if ((cmd.accept && single_load) || cmd.replay_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    dlefr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.accept && store),
        .wr_addr (store_addr),
        .wr_data (in_byte),
        .rd_en   (cmd.replay_read),
        .rd_addr (replay_idx_reg),
        .rd_data (rd_data)
    );

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_SUM;
            poly_reg       <= POLY_RESET;
            dle_reg        <= DLE_RESET;
            eof_reg        <= EOF_RESET;
            ack_reg        <= ACK_RESET;
            nak_reg        <= NAK_RESET;
            in_frame_reg   <= 1'b0;
            escape_reg     <= 1'b0;
            end_seen_reg   <= 1'b0;
            nak_pend_reg   <= 1'b0;
            count_reg      <= '0;
            chk_seen_reg   <= '0;
            check_reg      <= '0;
            command_reg    <= '0;
            replay_idx_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_MODE: mode_reg <= cfg_data[0];
                    CFG_POLY: poly_reg <= cfg_data;
                    CFG_DLE:  dle_reg  <= cfg_data[BYTE_W-1:0];
                    CFG_EOF:  eof_reg  <= cfg_data[BYTE_W-1:0];
                    CFG_ACK:  ack_reg  <= cfg_data[BYTE_W-1:0];
                    CFG_NAK:  nak_reg  <= cfg_data[BYTE_W-1:0];
                    default:  ;
                endcase
            end
            if (cmd.accept)
            begin
                in_frame_reg <= in_frame_next;
                escape_reg   <= escape_next;
                end_seen_reg <= end_seen_next;
                nak_pend_reg <= nak_pend_next;
                count_reg    <= count_next;
                chk_seen_reg <= chk_seen_next;
                check_reg    <= check_next;
                command_reg  <= command_next;
            end
            replay_idx_reg <= replay_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept && store)
        begin
            last_store_reg <= in_byte;
        end
        // Capture length and command before the frame state is dropped
        if (status.replay_start)
        begin
            replay_cnt_reg <= COUNT_W'(store_addr) + COUNT_W'(1);
            replay_cmd_reg <= single_cmd;
        end
        if (cmd.accept && single_load)
        begin
            out_kind_reg <= single_kind;
            out_fb_reg   <= '0;
            out_idx_reg  <= '0;
            out_cmd_reg  <= single_cmd;
            out_err_reg  <= single_err;
            out_last_reg <= 1'b1;
        end
        else if (cmd.replay_load)
        begin
            out_kind_reg <= KIND_DATA;
            out_fb_reg   <= rd_data;
            out_idx_reg  <= BYTE_INDEX_W'(replay_idx_reg);
            out_cmd_reg  <= replay_cmd_reg;
            out_err_reg  <= '0;
            out_last_reg <= status.replay_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_kind       = out_kind_reg;
    assign out_frame_byte = out_fb_reg;
    assign out_byte_index = out_idx_reg;
    assign out_command    = out_cmd_reg;
    assign out_error      = out_err_reg;
    assign out_last       = out_last_reg;

endmodule
